[rtl/core/etrm_pkg.sv]
// Package for the Euler angle to rotation matrix core: shared types, fixed-point
// constants and rounding helpers. Depends on nothing.
package etrm_pkg;

    // Default angle width: 2^(ANGLE_BITS-1) stands for pi radians.
    localparam int ANGLE_BITS_DEF = 16;
    // Fractional bits of the matrix entries.
    localparam int FRAC_BITS = 14;
    // Fractional bits of the internal sine, cosine and product values.
    localparam int WORK_FRAC = 30;
    // Pi in Q30.
    localparam logic [31:0] PI_Q30 = 32'd3373259426;
    // Register stages in the sine unit and in the matrix unit.
    localparam int SIN_LAT = 23;
    localparam int MAT_LAT = 6;
    localparam int LATENCY = SIN_LAT + MAT_LAT;

    // Signed Q30 value, range +-2^30.
    typedef logic signed [31:0] t_q30;

    // Sines and cosines of the three angles.
    typedef struct packed {
        t_q30 sf;
        t_q30 cf;
        t_q30 st;
        t_q30 ct;
        t_q30 sp;
        t_q30 cp;
    } t_trig;

    // Nine matrix entries, row-major, each Q1.14 in 16 bits.
    typedef struct packed {
        logic [8:0][15:0] e;
    } t_dcm;

    // Magnitude of a Q30 value; fits 31 bits since |v| <= 2^30.
    function automatic logic [30:0] mag30(input t_q30 v);
        logic [31:0] w_m;
        w_m = v[31] ? 32'(-v) : 32'(v);
        return w_m[30:0];
    endfunction

    // Rounds a raw magnitude product back to Q30, ties away from zero, and applies the sign.
    function automatic t_q30 round_q30(input logic [61:0] p, input logic neg);
        logic [61:0] w_s;
        logic [31:0] w_m;
        w_s = p + (62'd1 << (WORK_FRAC - 1));
        w_m = 32'(w_s >> WORK_FRAC);
        return neg ? -signed'(w_m) : signed'(w_m);
    endfunction

    // Rounds a Q30 entry to FRAC_BITS, ties away from zero, saturates to +-1.
    function automatic logic [15:0] quantize(input logic signed [32:0] v);
        logic [32:0] w_m;
        logic [32:0] w_r;
        logic signed [32:0] w_o;
        w_m = v[32] ? 33'(-v) : 33'(v);
        w_r = (w_m + (33'd1 << (WORK_FRAC - FRAC_BITS - 1))) >> (WORK_FRAC - FRAC_BITS);
        if (w_r > (33'd1 << FRAC_BITS)) begin
            w_r = 33'd1 << FRAC_BITS;
        end
        w_o = v[32] ? -signed'(w_r) : signed'(w_r);
        return w_o[15:0];
    endfunction

endpackage

[rtl/core/euler_to_rotation_matrix_core.sv]
// Top level of the Euler angle (ZYX) to rotation matrix core.
// Depends on etrm_pkg, etrm_sine and etrm_mat.
//
//  Channel  Valid    Ready    Payload
//  input    i_valid  o_ready  i_roll_angle, i_pitch_angle, i_yaw_angle
//  output   o_valid  i_ready  o_r0c0 .. o_r2c2
//
// One angle triple can be taken in every cycle while o_ready is high. Each beat
// passes 29 register stages (23 in the sine units, 6 in the product pipeline)
// on its way to the matrix outputs.
// Reset clears only the stage valid bits; data registers are not reset.
// The whole pipeline holds while the last stage has a beat that is not taken, and
// input ready drops for exactly those cycles, so nothing is lost or repeated.
module euler_to_rotation_matrix_core #(
    parameter int ANGLE_BITS = etrm_pkg::ANGLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_roll_angle,
    input  logic signed [15:0] i_pitch_angle,
    input  logic signed [15:0] i_yaw_angle,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_r0c0,
    output logic signed [15:0] o_r0c1,
    output logic signed [15:0] o_r0c2,
    output logic signed [15:0] o_r1c0,
    output logic signed [15:0] o_r1c1,
    output logic signed [15:0] o_r1c2,
    output logic signed [15:0] o_r2c0,
    output logic signed [15:0] o_r2c1,
    output logic signed [15:0] o_r2c2
);

    localparam int LAT = etrm_pkg::LATENCY;
    localparam logic [ANGLE_BITS-1:0] QTR = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    logic           w_en;
    logic [LAT-1:0] r_vld;

    // Pipeline advance: stall only when the last beat is held.
    assign w_en    = !r_vld[LAT-1] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // Angles sign-extended to the working width; cosine is the sine a quarter turn on.
    logic [ANGLE_BITS-1:0] w_ang [0:5];

    assign w_ang[0] = ANGLE_BITS'(i_roll_angle);
    assign w_ang[1] = ANGLE_BITS'(i_roll_angle) + QTR;
    assign w_ang[2] = ANGLE_BITS'(i_pitch_angle);
    assign w_ang[3] = ANGLE_BITS'(i_pitch_angle) + QTR;
    assign w_ang[4] = ANGLE_BITS'(i_yaw_angle);
    assign w_ang[5] = ANGLE_BITS'(i_yaw_angle) + QTR;

    etrm_pkg::t_q30 w_sin [0:5];

    for (genvar i = 0; i < 6; i++) begin : g_sin
        etrm_sine #(
            .ANGLE_BITS(ANGLE_BITS)
        ) u_sine (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_angle(w_ang[i]),
            .o_sine (w_sin[i])
        );
    end

    etrm_pkg::t_trig w_trig;
    etrm_pkg::t_dcm  w_dcm;

    assign w_trig.sf = w_sin[0];
    assign w_trig.cf = w_sin[1];
    assign w_trig.st = w_sin[2];
    assign w_trig.ct = w_sin[3];
    assign w_trig.sp = w_sin[4];
    assign w_trig.cp = w_sin[5];

    // Matrix products and output quantization.
    etrm_mat u_mat (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_trig(w_trig),
        .o_dcm (w_dcm)
    );

    assign o_r0c0 = signed'(w_dcm.e[0]);
    assign o_r0c1 = signed'(w_dcm.e[1]);
    assign o_r0c2 = signed'(w_dcm.e[2]);
    assign o_r1c0 = signed'(w_dcm.e[3]);
    assign o_r1c1 = signed'(w_dcm.e[4]);
    assign o_r1c2 = signed'(w_dcm.e[5]);
    assign o_r2c0 = signed'(w_dcm.e[6]);
    assign o_r2c1 = signed'(w_dcm.e[7]);
    assign o_r2c2 = signed'(w_dcm.e[8]);

endmodule

[rtl/core/etrm_sine.sv]
// Pipelined sine of one binary angle, Q30 result, by a seven-term Taylor series.
// Depends on etrm_pkg.
module etrm_sine #(
    parameter int ANGLE_BITS = etrm_pkg::ANGLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [ANGLE_BITS-1:0] i_angle,
    output etrm_pkg::t_q30        o_sine
);

    localparam int TW = ANGLE_BITS - 1;
    localparam int PW = TW + 32;
    localparam logic [TW-1:0] QLEN = TW'(1) << (ANGLE_BITS - 2);
    localparam int NTERM = 6;

    // Quadrant reduction.
    logic [1:0]    w_quad;
    logic [TW-1:0] w_r;
    logic [TW-1:0] n_t;
    logic [TW-1:0] r_t;
    logic          r_neg0;

    assign w_quad = i_angle[ANGLE_BITS-1:ANGLE_BITS-2];
    assign w_r    = TW'(i_angle[ANGLE_BITS-3:0]);
    assign n_t    = w_quad[0] ? (QLEN - w_r) : w_r;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t    <= n_t;
            r_neg0 <= w_quad[1];
        end
    end

    // Scale to Q30 radians.
    logic [PW-1:0] r_p1;
    logic          r_neg1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1   <= PW'(r_t) * PW'(etrm_pkg::PI_Q30);
            r_neg1 <= r_neg0;
        end
    end

    // Square of x.
    logic [30:0] w_x;
    logic [30:0] r_x;
    logic [61:0] r_xx;
    logic        r_neg2;

    assign w_x = 31'(r_p1 >> TW);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= w_x;
            r_xx   <= 62'(w_x) * 62'(w_x);
            r_neg2 <= r_neg1;
        end
    end

    // Series state after each term; entry zero holds the first term.
    logic [30:0]        r_term [0:NTERM];
    logic [31:0]        r_x2   [0:NTERM];
    logic signed [33:0] r_sum  [0:NTERM];
    logic               r_neg  [0:NTERM];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_term[0] <= r_x;
            r_x2[0]   <= 32'(r_xx >> etrm_pkg::WORK_FRAC);
            r_sum[0]  <= signed'(34'(r_x));
            r_neg[0]  <= r_neg2;
        end
    end

    // Each term: multiply by x^2, then divide by (2k)(2k+1) through a reciprocal.
    for (genvar k = 1; k <= NTERM; k++) begin : g_term
        localparam int D = (2 * k) * (2 * k + 1);
        localparam logic [31:0] M = 32'((64'd1 << 32) / D);
        localparam bit ODD = (k % 2) == 1;

        logic [62:0]        r_pa;
        logic [31:0]        r_xa;
        logic signed [33:0] r_sa;
        logic               r_na;
        logic [31:0]        w_v;
        logic [31:0]        r_v;
        logic [63:0]        r_qp;
        logic [31:0]        r_xb;
        logic signed [33:0] r_sb;
        logic               r_nb;
        logic [31:0]        w_q0;
        logic [32:0]        w_rem;
        logic [31:0]        w_q;

        // Product of the previous term and x^2.
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pa <= 63'(r_term[k-1]) * 63'(r_x2[k-1]);
                r_xa <= r_x2[k-1];
                r_sa <= r_sum[k-1];
                r_na <= r_neg[k-1];
            end
        end

        // Quotient estimate, at most one short of the true quotient.
        assign w_v = 32'(r_pa >> etrm_pkg::WORK_FRAC);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v  <= w_v;
                r_qp <= 64'(w_v) * 64'(M);
                r_xb <= r_xa;
                r_sb <= r_sa;
                r_nb <= r_na;
            end
        end

        // Correct the estimate and fold the term into the sum.
        assign w_q0  = 32'(r_qp >> 32);
        assign w_rem = 33'(r_v) - 33'(w_q0) * 33'(D);
        assign w_q   = w_q0 + ((w_rem >= 33'(D)) ? 32'd1 : 32'd0);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_term[k] <= w_q[30:0];
                r_x2[k]   <= r_xb;
                r_sum[k]  <= ODD ? (r_sb - signed'(34'(w_q))) : (r_sb + signed'(34'(w_q)));
                r_neg[k]  <= r_nb;
            end
        end
    end

    // Clamp to [0, 1] and apply the quadrant sign.
    logic signed [33:0] w_cl;
    etrm_pkg::t_q30     n_out;
    etrm_pkg::t_q30     r_out;

    always_comb begin
        w_cl = r_sum[NTERM];
        if (w_cl < 0) begin
            w_cl = '0;
        end
        if (w_cl > (34'sd1 <<< etrm_pkg::WORK_FRAC)) begin
            w_cl = 34'sd1 <<< etrm_pkg::WORK_FRAC;
        end
        n_out = r_neg[NTERM] ? -32'(w_cl) : 32'(w_cl);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_sine = r_out;

endmodule

[rtl/core/etrm_mat.sv]
// Matrix product pipeline: forms the nine entries from the six sines and cosines.
// Depends on etrm_pkg.
module etrm_mat (
    input  logic            i_clk,
    input  logic            i_en,
    input  etrm_pkg::t_trig i_trig,
    output etrm_pkg::t_dcm  o_dcm
);

    localparam int NP = 10;
    localparam int P_SFST = 0;
    localparam int P_CFST = 1;
    localparam int P_CTCP = 2;
    localparam int P_CTSP = 3;
    localparam int P_SFCT = 4;
    localparam int P_CFCT = 5;
    localparam int P_CFSP = 6;
    localparam int P_CFCP = 7;
    localparam int P_SFSP = 8;
    localparam int P_SFCP = 9;

    // First-level operand pairs.
    etrm_pkg::t_q30 w_a [0:NP-1];
    etrm_pkg::t_q30 w_b [0:NP-1];

    always_comb begin
        w_a[P_SFST] = i_trig.sf; w_b[P_SFST] = i_trig.st;
        w_a[P_CFST] = i_trig.cf; w_b[P_CFST] = i_trig.st;
        w_a[P_CTCP] = i_trig.ct; w_b[P_CTCP] = i_trig.cp;
        w_a[P_CTSP] = i_trig.ct; w_b[P_CTSP] = i_trig.sp;
        w_a[P_SFCT] = i_trig.sf; w_b[P_SFCT] = i_trig.ct;
        w_a[P_CFCT] = i_trig.cf; w_b[P_CFCT] = i_trig.ct;
        w_a[P_CFSP] = i_trig.cf; w_b[P_CFSP] = i_trig.sp;
        w_a[P_CFCP] = i_trig.cf; w_b[P_CFCP] = i_trig.cp;
        w_a[P_SFSP] = i_trig.sf; w_b[P_SFSP] = i_trig.sp;
        w_a[P_SFCP] = i_trig.sf; w_b[P_SFCP] = i_trig.cp;
    end

    // Stage one: first-level magnitude products.
    logic [61:0]    r1_p [0:NP-1];
    logic           r1_n [0:NP-1];
    etrm_pkg::t_q30 r1_st, r1_sp, r1_cp;
    // Stage two: rounded first-level products.
    etrm_pkg::t_q30 r2_q [0:NP-1];
    etrm_pkg::t_q30 r2_st, r2_sp, r2_cp;

    for (genvar i = 0; i < NP; i++) begin : g_p1
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r1_p[i] <= 62'(etrm_pkg::mag30(w_a[i])) * 62'(etrm_pkg::mag30(w_b[i]));
                r1_n[i] <= w_a[i][31] ^ w_b[i][31];
                r2_q[i] <= etrm_pkg::round_q30(r1_p[i], r1_n[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_st <= i_trig.st;
            r1_sp <= i_trig.sp;
            r1_cp <= i_trig.cp;
            r2_st <= r1_st;
            r2_sp <= r1_sp;
            r2_cp <= r1_cp;
        end
    end

    // Stage three: second-level products that form the four triple terms.
    etrm_pkg::t_q30 w_c [0:3];
    etrm_pkg::t_q30 w_d [0:3];
    logic [61:0]    r3_p [0:3];
    logic           r3_n [0:3];
    etrm_pkg::t_q30 r3_q [0:NP-1];
    etrm_pkg::t_q30 r3_st;
    // Stage four: rounded second-level products.
    etrm_pkg::t_q30 r4_s [0:3];
    etrm_pkg::t_q30 r4_q [0:NP-1];
    etrm_pkg::t_q30 r4_st;

    always_comb begin
        w_c[0] = r2_q[P_SFST]; w_d[0] = r2_cp;
        w_c[1] = r2_q[P_SFST]; w_d[1] = r2_sp;
        w_c[2] = r2_q[P_CFST]; w_d[2] = r2_cp;
        w_c[3] = r2_q[P_CFST]; w_d[3] = r2_sp;
    end

    for (genvar j = 0; j < 4; j++) begin : g_p2
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r3_p[j] <= 62'(etrm_pkg::mag30(w_c[j])) * 62'(etrm_pkg::mag30(w_d[j]));
                r3_n[j] <= w_c[j][31] ^ w_d[j][31];
                r4_s[j] <= etrm_pkg::round_q30(r3_p[j], r3_n[j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_q  <= r2_q;
            r3_st <= r2_st;
            r4_q  <= r3_q;
            r4_st <= r3_st;
        end
    end

    // Stage five: sums of the matrix entries.
    logic signed [32:0] r5_e [0:8];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_e[0] <= 33'(r4_q[P_CTCP]);
            r5_e[1] <= 33'(r4_q[P_CTSP]);
            r5_e[2] <= -33'(r4_st);
            r5_e[3] <= 33'(r4_s[0]) - 33'(r4_q[P_CFSP]);
            r5_e[4] <= 33'(r4_q[P_CFCP]) + 33'(r4_s[1]);
            r5_e[5] <= 33'(r4_q[P_SFCT]);
            r5_e[6] <= 33'(r4_q[P_SFSP]) + 33'(r4_s[2]);
            r5_e[7] <= 33'(r4_s[3]) - 33'(r4_q[P_SFCP]);
            r5_e[8] <= 33'(r4_q[P_CFCT]);
        end
    end

    // Stage six: output rounding and saturation.
    etrm_pkg::t_dcm r6_dcm;

    for (genvar e = 0; e < 9; e++) begin : g_q
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r6_dcm.e[e] <= etrm_pkg::quantize(r5_e[e]);
            end
        end
    end

    assign o_dcm = r6_dcm;

endmodule
